// File: rtl/jet_pkg.sv
// Shared types and constants for the Julia escape-time unit.
// Holds the controller state type, the command and status structs and the Q4.28 helpers.
// Depends on nothing.
package jet_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFFS,
		ST_LOAD,
		ST_MUL,
		ST_UPD
	} jet_state_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_C_REAL      = 3'd0;
	localparam logic [2:0] CFG_C_IMAG      = 3'd1;
	localparam logic [2:0] CFG_CENTER_REAL = 3'd2;
	localparam logic [2:0] CFG_CENTER_IMAG = 3'd3;
	localparam logic [2:0] CFG_STEP_REAL   = 3'd4;
	localparam logic [2:0] CFG_STEP_IMAG   = 3'd5;
	localparam logic [2:0] CFG_MAX_ITER    = 3'd6;

	localparam logic [30:0] STEP_REAL_RST = 31'd12582912;
	localparam logic [30:0] STEP_IMAG_RST = 31'd16777216;
	localparam logic [7:0]  MAX_ITER_RST  = 8'd100;

	// 4.0 in Q8.56, the scale of a sum of two Q4.28 squares
	localparam logic [63:0] ESC_MAG = 64'h0400_0000_0000_0000;

	localparam int FRAC_BITS = 28;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	typedef struct packed {
		logic capture;
		logic offs;
		logic load;
		logic mul;
		logic upd;
	} jet_cmd_t;

	typedef struct packed {
		logic escape;
		logic limit;
	} jet_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/jet_ctrl.sv
// Sequencer of the Julia escape-time unit.
// Steps each pixel through offset, load and multiply/update rounds.
// Depends on jet_pkg.
module jet_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  jet_pkg::jet_status_t status,
	output jet_pkg::jet_cmd_t    cmd,
	output logic                busy
);

	jet_pkg::jet_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jet_pkg::ST_IDLE: begin
				if (start) state_d = jet_pkg::ST_OFFS;
			end
			jet_pkg::ST_OFFS: state_d = jet_pkg::ST_LOAD;
			jet_pkg::ST_LOAD: state_d = jet_pkg::ST_MUL;
			jet_pkg::ST_MUL:  state_d = jet_pkg::ST_UPD;
			jet_pkg::ST_UPD: begin
				if (status.escape || status.limit) state_d = jet_pkg::ST_IDLE;
				else state_d = jet_pkg::ST_MUL;
			end
			default: state_d = jet_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			jet_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			jet_pkg::ST_OFFS: cmd.offs = 1'b1;
			jet_pkg::ST_LOAD: cmd.load = 1'b1;
			jet_pkg::ST_MUL:  cmd.mul  = 1'b1;
			jet_pkg::ST_UPD:  cmd.upd  = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	a_accept_to_offs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == jet_pkg::ST_OFFS))
		else $error("accepted word did not enter offset phase");

	a_upd_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && !status.escape && !status.limit) |=> cmd.mul)
		else $error("unfinished pixel left the iteration loop");

endmodule

// File: rtl/jet_datapath.sv
// Datapath of the Julia escape-time unit: start point mapping, shared complex
// squaring unit, escape test and result registers. Depends on jet_pkg.
module jet_datapath #(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jet_pkg::jet_cmd_t    cmd,
	output jet_pkg::jet_status_t status,
	input  logic [5:0]           pixel_x,
	input  logic [4:0]           pixel_y,
	input  logic signed [31:0]   c_real,
	input  logic signed [31:0]   c_imag,
	input  logic signed [31:0]   center_real,
	input  logic signed [31:0]   center_imag,
	input  logic [30:0]          step_real,
	input  logic [30:0]          step_imag,
	input  logic [7:0]           max_iterations,
	output logic                 done,
	output logic [5:0]           out_x,
	output logic [4:0]           out_y,
	output logic [7:0]           iter_count,
	output logic                 escaped
);

	// Signed width of 2*x - WIDTH and 2*y - HEIGHT
	localparam int XOW = $clog2((WIDTH > 128) ? WIDTH : 128) + 2;
	localparam int YOW = $clog2((HEIGHT > 64) ? HEIGHT : 64) + 2;
	localparam int XPW = XOW + 32;
	localparam int YPW = YOW + 32;

	logic [5:0]            x_q;
	logic [4:0]            y_q;
	logic signed [XPW-1:0] off_r_q;
	logic signed [YPW-1:0] off_i_q;
	logic signed [31:0]    zr_q, zi_q;
	logic signed [63:0]    rr_q, ii_q, ri_q;
	logic [7:0]            k_q;

	logic signed [XOW-1:0] xo;
	logic signed [YOW-1:0] yo;
	logic signed [31:0]    step_r_s, step_i_s;
	logic signed [31:0]    zr0, zi0, nr, ni;
	logic [63:0]           mag;
	logic                  esc, lim;

	assign xo       = XOW'({1'b0, x_q, 1'b0}) - XOW'(WIDTH);
	assign yo       = YOW'({1'b0, y_q, 1'b0}) - YOW'(HEIGHT);
	assign step_r_s = $signed({1'b0, step_real});
	assign step_i_s = $signed({1'b0, step_imag});

	assign zr0 = jet_pkg::sat32(64'(center_real) + 64'(off_r_q >>> 1));
	assign zi0 = jet_pkg::sat32(64'(center_imag) + 64'(off_i_q >>> 1));

	assign nr = jet_pkg::sat32(((rr_q - ii_q) >>> jet_pkg::FRAC_BITS) + 64'(c_real));
	assign ni = jet_pkg::sat32((ri_q >>> (jet_pkg::FRAC_BITS - 1)) + 64'(c_imag));

	// Products held in UPD are those of the current z, so their sum is its |z|^2
	assign mag = $unsigned(rr_q) + $unsigned(ii_q);
	assign esc = (k_q != 8'd0) && (mag > jet_pkg::ESC_MAG);
	assign lim = (k_q == max_iterations);

	assign status.escape = esc;
	assign status.limit  = lim;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= pixel_x;
			y_q <= pixel_y;
		end
		if (cmd.offs) begin
			off_r_q <= XPW'(xo) * XPW'(step_r_s);
			off_i_q <= YPW'(yo) * YPW'(step_i_s);
		end
		if (cmd.load) begin
			zr_q <= zr0;
			zi_q <= zi0;
			k_q  <= '0;
		end
		if (cmd.mul) begin
			rr_q <= 64'(zr_q) * 64'(zr_q);
			ii_q <= 64'(zi_q) * 64'(zi_q);
			ri_q <= 64'(zr_q) * 64'(zi_q);
		end
		if (cmd.upd && !esc && !lim) begin
			zr_q <= nr;
			zi_q <= ni;
			k_q  <= k_q + 8'd1;
		end
		if (cmd.upd && (esc || lim)) begin
			out_x      <= x_q;
			out_y      <= y_q;
			iter_count <= esc ? (k_q - 8'd1) : k_q;
			escaped    <= esc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.upd && (esc || lim);
		end
	end

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.upd))
		else $error("result strobe without a final update");

	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && escaped) |-> (iter_count != 8'hFF))
		else $error("escaped word carries an impossible count");

endmodule

// File: rtl/julia_escape_time_unit.sv
// Top level of the Julia escape-time unit: configuration registers,
// controller and datapath. Depends on jet_pkg, jet_ctrl and jet_datapath.
//
// channel  direction  handshake                 payload
// cmd      in         start & !busy             pixel_x, pixel_y
// result   out        done (one cycle strobe)   out_x, out_y, iter_count, escaped
// cfg      in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A pixel runs from accept through an offset state and a load state, then loops over
// iterations until it escapes or its count reaches max_iterations; each iteration is a
// multiply state and an update state through the one shared complex squaring unit.
// busy falls in the strobe cycle, so the next word can be accepted right then.
// Reset clears control and loads register defaults; results cannot be stalled.
// cfg_ready is always high.
module julia_escape_time_unit #(
	parameter int WIDTH  = 64,
	parameter int HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  pixel_x,
	input  logic [4:0]  pixel_y,
	output logic        done,
	output logic [5:0]  out_x,
	output logic [4:0]  out_y,
	output logic [7:0]  iter_count,
	output logic        escaped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] c_real_q, c_imag_q, center_real_q, center_imag_q;
	logic [30:0]        step_real_q, step_imag_q;
	logic [7:0]         max_iter_q;

	jet_pkg::jet_cmd_t    cmd;
	jet_pkg::jet_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q      <= '0;
			c_imag_q      <= '0;
			center_real_q <= '0;
			center_imag_q <= '0;
			step_real_q   <= jet_pkg::STEP_REAL_RST;
			step_imag_q   <= jet_pkg::STEP_IMAG_RST;
			max_iter_q    <= jet_pkg::MAX_ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jet_pkg::CFG_C_REAL:      c_real_q      <= $signed(cfg_data);
				jet_pkg::CFG_C_IMAG:      c_imag_q      <= $signed(cfg_data);
				jet_pkg::CFG_CENTER_REAL: center_real_q <= $signed(cfg_data);
				jet_pkg::CFG_CENTER_IMAG: center_imag_q <= $signed(cfg_data);
				jet_pkg::CFG_STEP_REAL:   step_real_q   <= cfg_data[30:0];
				jet_pkg::CFG_STEP_IMAG:   step_imag_q   <= cfg_data[30:0];
				jet_pkg::CFG_MAX_ITER:    max_iter_q    <= cfg_data[7:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	jet_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	jet_datapath #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.c_real         (c_real_q),
		.c_imag         (c_imag_q),
		.center_real    (center_real_q),
		.center_imag    (center_imag_q),
		.step_real      (step_real_q),
		.step_imag      (step_imag_q),
		.max_iterations (max_iter_q),
		.done           (done),
		.out_x          (out_x),
		.out_y          (out_y),
		.iter_count     (iter_count),
		.escaped        (escaped)
	);

endmodule
